[rtl/ccv_pkg.sv]
package ccv_pkg;

  // Default depth of the checksum chain.
  localparam int MAX_CHAIN_DEF = 4;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 3;
  localparam int ALGO_W   = 3;
  localparam int ENTRY_W  = 2;
  localparam int WORD_W   = 32;
  localparam int N_ALGO   = 4;
  localparam int CFG_A_W  = 3;
  localparam int OUT_TD_W = 40;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_CHAIN_LEN   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_ALGO_FIRST  = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_ALGO_FOURTH = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] CHAIN_LEN_RST = 3'd2;

  // Checksum constants.
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [8:0]  FL16_MOD   = 9'd255;
  localparam logic [16:0] FL32_MOD   = 17'd65535;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;

  // Algorithm codes; the two unused codes compute zero.
  typedef enum logic [ALGO_W-1:0] {
    ALGO_CRC16   = 3'd0,
    ALGO_CRC32   = 3'd1,
    ALGO_FL16    = 3'd2,
    ALGO_FL32    = 3'd3,
    ALGO_ADLER32 = 3'd4,
    ALGO_XORFOLD = 3'd5
  } algo_t;

  localparam logic [ALGO_W-1:0] ALGO_NONE = 3'd7;

  typedef logic [N_ALGO-1:0][ALGO_W-1:0] algo_arr_t;

  // Running checksum state of one frame.
  typedef struct packed {
    logic [15:0] crc16;
    logic [31:0] crc32;
    logic [15:0] fl16;
    logic [31:0] fl32;
    logic [15:0] adler_a;
    logic [15:0] adler_b;
    logic [31:0] xor_acc;
    logic [1:0]  byte_lane;
  } sums_t;

  // Control from the trailer checker to the checksum engine.
  typedef struct packed {
    logic absorb;
    logic restart;
    logic frame_end;
  } sums_ctl_t;

  // One verification result.
  typedef struct packed {
    logic               verify_ok;
    logic [ENTRY_W-1:0] bad_entry;
    logic [WORD_W-1:0]  bad_computed;
  } result_t;

endpackage

[rtl/checksum_chain_verifier.sv]
// Channel  | Dir | Handshake           | Word
// in_      | in  | in_tvalid/tready    | tdata data_byte, tuser is_trailer
// out_     | out | out_tvalid/tready   | tdata verify_ok, bad_entry, bad_computed
// cfg_     | in  | cfg_valid/cfg_ready | cfg_addr register index, cfg_data value
//
// One byte a cycle unless stalled: a word is taken into the input register,
// then the checksum update and the trailer compare run combinationally into
// the state and the result register. A result word is offered from the
// result register after its last trailer byte leaves the input register.
// Reset is synchronous on rst_n and restores the register defaults.
// The input side stalls only when its register is full and a result is
// still waiting at the output; configuration writes are always taken.
module checksum_chain_verifier #(
  parameter int MAX_CHAIN = ccv_pkg::MAX_CHAIN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tuser,   // [0] is_trailer
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] verify_ok, [2:1] bad_entry, [34:3] bad_computed, [39:35] zero
  output logic [ccv_pkg::OUT_TD_W-1:0] out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ccv_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [ccv_pkg::CFG_W-1:0]    cfg_data
);
  import ccv_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_trail_r;
  logic               advance, fire, in_take;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, res;
  logic               res_valid;
  logic [CFG_W-1:0]   chain_len_r;
  algo_arr_t          algo_r;
  sums_ctl_t          ctl;
  sums_t              sums;
  logic [CFG_A_W-1:0] algo_sel;

  // Input register handshake.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_tdata;
      in_trail_r <= in_tuser;
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign algo_sel  = cfg_addr - CFG_ALGO_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r <= CHAIN_LEN_RST;
      algo_r[0]   <= ALGO_CRC16;
      algo_r[1]   <= ALGO_ADLER32;
      algo_r[2]   <= ALGO_CRC16;
      algo_r[3]   <= ALGO_CRC16;
    end else if (cfg_valid) begin
      if (cfg_addr == CFG_CHAIN_LEN) begin
        chain_len_r <= cfg_data;
      end else if (cfg_addr >= CFG_ALGO_FIRST && cfg_addr <= CFG_ALGO_FOURTH) begin
        algo_r[algo_sel[ENTRY_W-1:0]] <= cfg_data;
      end
    end
  end

  ccv_sums u_sums (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (in_byte_r),
    .sums      (sums)
  );

  ccv_trailer #(
    .MAX_CHAIN (MAX_CHAIN)
  ) u_trailer (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .data_byte    (in_byte_r),
    .is_trailer   (in_trail_r),
    .chain_length (chain_len_r),
    .algo         (algo_r),
    .sums         (sums),
    .ctl          (ctl),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.bad_computed, out_res_r.bad_entry,
                       out_res_r.verify_ok};

endmodule

[rtl/ccv_sums.sv]
module ccv_sums (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ccv_pkg::sums_ctl_t       ctl,
  input  logic [ccv_pkg::BYTE_W-1:0] data_byte,
  output ccv_pkg::sums_t           sums
);
  import ccv_pkg::*;

  sums_t sums_r, sums_nxt, base, upd, rst_val;

  logic [15:0] c16;
  logic [31:0] c32;
  logic [8:0]  f16_s1, f16_s2;
  logic [16:0] f32_s1, f32_s2;
  logic [16:0] ad_a, ad_b;

  assign sums = sums_r;

  // Frame start values.
  always_comb begin
    rst_val           = '0;
    rst_val.crc16     = CRC16_INIT;
    rst_val.crc32     = CRC32_INIT;
    rst_val.adler_a   = 16'd1;
  end

  // A payload byte that breaks into a trailer starts from fresh values.
  assign base = ctl.restart ? rst_val : sums_r;

  // Absorb one byte into every checksum.
  always_comb begin
    upd = base;

    c16 = base.crc16 ^ {data_byte, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c16 = c16[15] ? ((c16 << 1) ^ CRC16_POLY) : (c16 << 1);
    end
    upd.crc16 = c16;

    c32 = base.crc32 ^ {24'h000000, data_byte};
    for (int k = 0; k < 8; k++) begin
      c32 = c32[0] ? ((c32 >> 1) ^ CRC32_POLY) : (c32 >> 1);
    end
    upd.crc32 = c32;

    // Sums stay below the modulus, so one subtract reduces each add.
    f16_s1 = {1'b0, base.fl16[7:0]} + {1'b0, data_byte};
    if (f16_s1 >= FL16_MOD) begin
      f16_s1 = f16_s1 - FL16_MOD;
    end
    f16_s2 = {1'b0, base.fl16[15:8]} + f16_s1;
    if (f16_s2 >= FL16_MOD) begin
      f16_s2 = f16_s2 - FL16_MOD;
    end
    upd.fl16 = {f16_s2[7:0], f16_s1[7:0]};

    f32_s1 = {1'b0, base.fl32[15:0]} + {9'd0, data_byte};
    if (f32_s1 >= FL32_MOD) begin
      f32_s1 = f32_s1 - FL32_MOD;
    end
    f32_s2 = {1'b0, base.fl32[31:16]} + f32_s1;
    if (f32_s2 >= FL32_MOD) begin
      f32_s2 = f32_s2 - FL32_MOD;
    end
    upd.fl32 = {f32_s2[15:0], f32_s1[15:0]};

    ad_a = {1'b0, base.adler_a} + {9'd0, data_byte};
    if (ad_a >= ADLER_MOD) begin
      ad_a = ad_a - ADLER_MOD;
    end
    ad_b = {1'b0, base.adler_b} + ad_a;
    if (ad_b >= ADLER_MOD) begin
      ad_b = ad_b - ADLER_MOD;
    end
    upd.adler_a = ad_a[15:0];
    upd.adler_b = ad_b[15:0];

    // The xor fold places byte i in lane i mod 4.
    case (base.byte_lane)
      2'd0:    upd.xor_acc = base.xor_acc ^ {24'h000000, data_byte};
      2'd1:    upd.xor_acc = base.xor_acc ^ {16'h0000, data_byte, 8'h00};
      2'd2:    upd.xor_acc = base.xor_acc ^ {8'h00, data_byte, 16'h0000};
      default: upd.xor_acc = base.xor_acc ^ {data_byte, 24'h000000};
    endcase
    upd.byte_lane = base.byte_lane + 2'd1;
  end

  // Next state of the checksum registers.
  always_comb begin
    sums_nxt = sums_r;
    if (ctl.frame_end) begin
      sums_nxt = rst_val;
    end else if (ctl.absorb) begin
      sums_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= rst_val;
    end else begin
      sums_r <= sums_nxt;
    end
  end

endmodule

[rtl/ccv_trailer.sv]
module ccv_trailer #(
  parameter int MAX_CHAIN = ccv_pkg::MAX_CHAIN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [ccv_pkg::BYTE_W-1:0] data_byte,
  input  logic                       is_trailer,
  input  logic [ccv_pkg::CFG_W-1:0]  chain_length,
  input  ccv_pkg::algo_arr_t         algo,
  input  ccv_pkg::sums_t             sums,
  output ccv_pkg::sums_ctl_t         ctl,
  output logic                       res_valid,
  output ccv_pkg::result_t           res
);
  import ccv_pkg::*;

  // The entry counter must also be able to hold the count of named entries.
  localparam int CNT_RAW = $clog2(MAX_CHAIN + 1);
  localparam int CNT_W   = (CNT_RAW > ENTRY_W) ? CNT_RAW : ENTRY_W + 1;

  logic [WORD_W-1:0]  exp_r, exp_nxt, exp_word;
  logic [1:0]         tbytes_r, tbytes_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc, len_eff;
  logic               miss_r, miss_nxt;
  logic [ENTRY_W-1:0] bad_idx_r, bad_idx_nxt;
  logic [WORD_W-1:0]  bad_val_r, bad_val_nxt;
  logic [ALGO_W-1:0]  code;
  logic [WORD_W-1:0]  computed;
  logic               in_trailer, word_done, miss_now, frame_done;

  // Effective chain length: zero counts as one, the top is clamped.
  always_comb begin
    if (chain_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(chain_length) > MAX_CHAIN) begin
      len_eff = CNT_W'(MAX_CHAIN);
    end else begin
      len_eff = CNT_W'(chain_length);
    end
  end

  // Value of the algorithm of the current entry.
  assign code = (cnt_r < CNT_W'(N_ALGO)) ? algo[cnt_r[ENTRY_W-1:0]] : ALGO_NONE;

  always_comb begin
    case (code)
      ALGO_CRC16:   computed = {16'h0000, sums.crc16};
      ALGO_CRC32:   computed = sums.crc32 ^ CRC32_INIT;
      ALGO_FL16:    computed = {16'h0000, sums.fl16};
      ALGO_FL32:    computed = sums.fl32;
      ALGO_ADLER32: computed = {sums.adler_b, sums.adler_a};
      ALGO_XORFOLD: computed = sums.xor_acc;
      default:      computed = '0;
    endcase
  end

  assign in_trailer = (cnt_r != '0) || (tbytes_r != 2'd0);
  assign exp_word   = {exp_r[WORD_W-BYTE_W-1:0], data_byte};
  assign word_done  = fire && is_trailer && (tbytes_r == 2'd3);
  assign miss_now   = (computed != exp_word) && !miss_r;
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign frame_done = word_done && (cnt_inc >= len_eff);

  // Control toward the checksum engine.
  always_comb begin
    ctl.absorb    = fire && !is_trailer;
    ctl.restart   = fire && !is_trailer && in_trailer;
    ctl.frame_end = frame_done;
  end

  // Trailer assembly and the first-mismatch record.
  always_comb begin
    exp_nxt     = exp_r;
    tbytes_nxt  = tbytes_r;
    cnt_nxt     = cnt_r;
    miss_nxt    = miss_r;
    bad_idx_nxt = bad_idx_r;
    bad_val_nxt = bad_val_r;
    if (fire && !is_trailer) begin
      if (in_trailer) begin
        exp_nxt     = '0;
        tbytes_nxt  = 2'd0;
        cnt_nxt     = '0;
        miss_nxt    = 1'b0;
        bad_idx_nxt = '0;
        bad_val_nxt = '0;
      end
    end else if (fire) begin
      tbytes_nxt = tbytes_r + 2'd1;
      if (!word_done) begin
        exp_nxt = exp_word;
      end else if (frame_done) begin
        exp_nxt     = '0;
        cnt_nxt     = '0;
        miss_nxt    = 1'b0;
        bad_idx_nxt = '0;
        bad_val_nxt = '0;
      end else begin
        exp_nxt = '0;
        cnt_nxt = cnt_inc;
        if (miss_now) begin
          miss_nxt    = 1'b1;
          bad_idx_nxt = cnt_r[ENTRY_W-1:0];
          bad_val_nxt = computed;
        end
      end
    end
  end

  // Result of a completed frame.
  always_comb begin
    res_valid = frame_done;
    res       = '0;
    if (miss_r) begin
      res.bad_entry    = bad_idx_r;
      res.bad_computed = bad_val_r;
    end else if (miss_now) begin
      res.bad_entry    = cnt_r[ENTRY_W-1:0];
      res.bad_computed = computed;
    end else begin
      res.verify_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r     <= '0;
      tbytes_r  <= 2'd0;
      cnt_r     <= '0;
      miss_r    <= 1'b0;
      bad_idx_r <= '0;
      bad_val_r <= '0;
    end else begin
      exp_r     <= exp_nxt;
      tbytes_r  <= tbytes_nxt;
      cnt_r     <= cnt_nxt;
      miss_r    <= miss_nxt;
      bad_idx_r <= bad_idx_nxt;
      bad_val_r <= bad_val_nxt;
    end
  end

endmodule
